@@ rtl/core/hsrs_pkg.sv @@
// Package for the hash slot range splitter: table size, derived widths,
// status and action codes, request and response payload types and the sequencer states.
// No dependencies.
package hsrs_pkg;

   localparam int SLOTS  = 64;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);

   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic        action;
      logic [5:0]  slot;
      logic [15:0] node_port;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  node_id;
      logic [6:0]  range_start;
      logic [6:0]  range_end;
      logic [15:0] port_out;
   } rsp_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_WALK_A = 8'b0000_0010,
      ST_WALK_B = 8'b0000_0100,
      ST_SPLIT  = 8'b0000_1000,
      ST_FILL   = 8'b0001_0000,
      ST_LK_A   = 8'b0010_0000,
      ST_LK_B   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

endpackage

@@ rtl/core/hash_slot_range_splitter_unit.sv @@
// Top level of the hash slot range splitter: sequencer, slot owner table,
// node end and node tag tables, and the response register.
// Depends on hsrs_pkg and hsrs_ram.
//
// Usage: requests arrive on the req_ channel (valid/stall) as one req_type
// transfer; each produces exactly one rsp_type transfer on the rsp_ channel.
// The block works on one request at a time and holds req_stall high from the
// accepting edge until the result has been moved into the response register.
// A lookup reads the slot owner, then the node end and tag, stages the result
// and moves it into the response register; the next request can be taken once
// the sequencer is back in idle. An add walks the ranges in the WALK_A and
// WALK_B states to find the widest, computes the split point, and writes the
// owner of each slot that the new node takes before it writes the node end and
// tag; the first add skips the walk and gives the new node all SLOTS slots. A
// full table or an empty lookup goes straight to the done state.
// Reset clears the node count, the sequencer and the response valid flag;
// the tables need no clearing pass; no entry is used before it is written.
// While the receiver stalls, the response register holds its transfer; the next
// request is worked on and waits in its final state until the register is free.
module hash_slot_range_splitter_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hsrs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hsrs_pkg::rsp_type rsp_data
);

   localparam int SLOT_W = hsrs_pkg::SLOT_W;
   localparam int CNT_W  = hsrs_pkg::CNT_W;
   localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(hsrs_pkg::SLOTS);

   hsrs_pkg::state_type state_ff, state_in;
   hsrs_pkg::req_type   cur_ff, cur_in;
   hsrs_pkg::rsp_type   res_ff, res_in;
   hsrs_pkg::rsp_type   rsp_data_ff;
   logic                rsp_valid_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  best_ff, best_in;
   logic [CNT_W-1:0]  bstart_ff, bstart_in;
   logic [CNT_W-1:0]  bend_ff, bend_in;
   logic [CNT_W-1:0]  mid_ff, mid_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0] id_ff, id_in;

   logic [SLOT_W-1:0] own_rd_addr, own_rd_data;
   logic              own_we;
   logic [SLOT_W-1:0] node_rd_addr;
   logic [CNT_W-1:0]  end_rd_data;
   logic [15:0]       tag_rd_data;
   logic              node_we;
   logic              own_bad;
   logic [SLOT_W-1:0] slot_sat;
   logic [CNT_W-1:0]  span;
   logic              rsp_free;

   hsrs_ram #(.WIDTH(SLOT_W), .DEPTH(hsrs_pkg::SLOTS)) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (idx_ff[SLOT_W-1:0]),
      .wr_data (id_ff),
      .rd_addr (own_rd_addr),
      .rd_data (own_rd_data)
   );

   hsrs_ram #(.WIDTH(CNT_W), .DEPTH(hsrs_pkg::SLOTS)) u_end_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (id_ff),
      .wr_data (mid_ff),
      .rd_addr (node_rd_addr),
      .rd_data (end_rd_data)
   );

   hsrs_ram #(.WIDTH(16), .DEPTH(hsrs_pkg::SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (id_ff),
      .wr_data (cur_ff.node_port),
      .rd_addr (node_rd_addr),
      .rd_data (tag_rd_data)
   );

   assign own_bad      = (CNT_W'(own_rd_data) >= SLOTS_C);
   assign node_rd_addr = own_bad ? '0 : own_rd_data;
   assign slot_sat     = (32'(req_data.slot) >= hsrs_pkg::SLOTS) ?
                         SLOT_W'(hsrs_pkg::SLOTS - 1) : SLOT_W'(req_data.slot);
   assign span         = end_rd_data - pos_ff;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      res_in      = res_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      best_in     = best_ff;
      bstart_in   = bstart_ff;
      bend_in     = bend_ff;
      mid_in      = mid_ff;
      idx_in      = idx_ff;
      id_in       = id_ff;
      own_rd_addr = '0;
      own_we      = 1'b0;
      node_we     = 1'b0;

      case (state_ff)
         hsrs_pkg::ST_IDLE: begin
            if (req_data.action == hsrs_pkg::ACT_LOOKUP) begin
               own_rd_addr = slot_sat;
            end
            if (req_valid) begin
               cur_in = req_data;
               id_in  = count_ff[SLOT_W-1:0];
               if (req_data.action == hsrs_pkg::ACT_ADD) begin
                  if (count_ff >= SLOTS_C) begin
                     res_in = '{status: hsrs_pkg::STATUS_FULL, default: '0};
                     state_in = hsrs_pkg::ST_DONE;
                  end else if (count_ff == '0) begin
                     bstart_in = '0;
                     mid_in    = SLOTS_C;
                     idx_in    = '0;
                     state_in  = hsrs_pkg::ST_FILL;
                  end else begin
                     pos_in    = '0;
                     best_in   = '0;
                     bstart_in = '0;
                     bend_in   = '0;
                     state_in  = hsrs_pkg::ST_WALK_A;
                  end
               end else if (count_ff == '0) begin
                  res_in = '{status: hsrs_pkg::STATUS_EMPTY, default: '0};
                  state_in = hsrs_pkg::ST_DONE;
               end else begin
                  state_in = hsrs_pkg::ST_LK_A;
               end
            end
         end
         hsrs_pkg::ST_WALK_A: begin
            state_in = own_bad ? hsrs_pkg::ST_SPLIT : hsrs_pkg::ST_WALK_B;
         end
         hsrs_pkg::ST_WALK_B: begin
            own_rd_addr = end_rd_data[SLOT_W-1:0];
            if (end_rd_data <= pos_ff || end_rd_data > SLOTS_C) begin
               state_in = hsrs_pkg::ST_SPLIT;
            end else begin
               if (span > best_ff) begin
                  best_in   = span;
                  bstart_in = pos_ff;
                  bend_in   = end_rd_data;
               end
               pos_in   = end_rd_data;
               state_in = (end_rd_data >= SLOTS_C) ? hsrs_pkg::ST_SPLIT
                                                   : hsrs_pkg::ST_WALK_A;
            end
         end
         hsrs_pkg::ST_SPLIT: begin
            mid_in   = bstart_ff + ((bend_ff - bstart_ff) >> 1);
            idx_in   = bstart_ff;
            state_in = hsrs_pkg::ST_FILL;
         end
         hsrs_pkg::ST_FILL: begin
            if (idx_ff < mid_ff) begin
               own_we = 1'b1;
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               node_we  = 1'b1;
               count_in = count_ff + CNT_W'(1);
               res_in.status      = hsrs_pkg::STATUS_OK;
               res_in.node_id     = 6'(id_ff);
               res_in.range_start = 7'(bstart_ff);
               res_in.range_end   = 7'(mid_ff);
               res_in.port_out    = cur_ff.node_port;
               state_in = hsrs_pkg::ST_DONE;
            end
         end
         hsrs_pkg::ST_LK_A: begin
            id_in    = node_rd_addr;
            state_in = hsrs_pkg::ST_LK_B;
         end
         hsrs_pkg::ST_LK_B: begin
            res_in.status      = hsrs_pkg::STATUS_OK;
            res_in.node_id     = 6'(id_ff);
            res_in.range_start = '0;
            res_in.range_end   = 7'(end_rd_data);
            res_in.port_out    = tag_rd_data;
            state_in = hsrs_pkg::ST_DONE;
         end
         hsrs_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = hsrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hsrs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hsrs_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == hsrs_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      res_ff    <= res_in;
      pos_ff    <= pos_in;
      best_ff   <= best_in;
      bstart_ff <= bstart_in;
      bend_ff   <= bend_in;
      mid_ff    <= mid_in;
      idx_ff    <= idx_in;
      id_ff     <= id_in;
      if (state_ff == hsrs_pkg::ST_DONE && rsp_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign req_stall = (state_ff != hsrs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The node count never passes the table size.
   assert property (@(posedge clock) disable iff (reset) count_ff <= SLOTS_C)
      else $error("node count exceeds table size");

   // An add on a full table leaves the node count unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.action == hsrs_pkg::ACT_ADD &&
       count_ff >= SLOTS_C) |=> $stable(count_ff))
      else $error("add on full table changed node count");

   // A new response only appears after the sequencer has finished an item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == hsrs_pkg::ST_DONE))
      else $error("response raised outside the done state");

   // Slot owner writes only happen in the fill state and inside the table.
   assert property (@(posedge clock) disable iff (reset)
      own_we |-> (state_ff == hsrs_pkg::ST_FILL && idx_ff < SLOTS_C))
      else $error("slot owner write outside the table");

endmodule

@@ rtl/core/hsrs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hsrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
